[design/chtbl_pkg.sv]
// Package for the chained hash table: field widths, codes, hashing constants,
// the controller state type and the command and status structs.
// Depends on nothing; every other design file but chtbl_ram imports it.
`default_nettype none

package chtbl_pkg;

   localparam int unsigned BUCKETS_DEF    = 20;
   localparam int unsigned POOL_NODES_DEF = 256;

   localparam int unsigned KEY_W    = 31;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned MODE_W   = 2;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   localparam logic [MODE_W-1:0] MODE_KEY    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DIGITS = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RESET  = MODE_DIGITS;

   // Division by ten through the reciprocal, exact for any 32-bit dividend.
   localparam int unsigned       RECIP_W    = 32;
   localparam logic [RECIP_W-1:0] RECIP_10  = 32'hCCCC_CCCD;
   localparam int unsigned       PROD_W     = KEY_W + RECIP_W;
   localparam int unsigned       QUOT_SHIFT = 35;
   localparam int unsigned       QUOT_W     = PROD_W - QUOT_SHIFT;
   localparam int unsigned       DIGIT_W    = 4;
   localparam int unsigned       SUM_W      = 7;
   localparam int unsigned       LIN_W      = KEY_W + 2;

   // Remainder unit: a 36-bit dividend taken four bits per cycle.
   localparam int unsigned DIV_W     = 36;
   localparam int unsigned MOD_BITS  = 4;
   localparam int unsigned MOD_STEPS = DIV_W / MOD_BITS;
   localparam int unsigned MOD_CNT_W = $clog2(MOD_STEPS + 1);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIGIT_MUL,
      ST_DIGIT_ACC,
      ST_MOD,
      ST_HEAD,
      ST_WALK,
      ST_NODE,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic start;
      logic mul;
      logic acc;
      logic mod_load;
      logic mod_step;
   } hash_cmd_type;

   typedef struct packed {
      logic work_zero;
      logic mod_done;
   } hash_status_type;

   typedef struct packed {
      hash_cmd_type hash;
      logic         clear_wr;
      logic         load;
      logic         ins_wr;
      logic         ptr_head;
      logic         ptr_link;
      logic         res_set;
      status_type   res_status;
      logic         res_value;
      logic         rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic mode_digits;
      logic work_zero;
      logic mod_done;
      logic is_lookup;
      logic pool_full;
      logic ptr_empty;
      logic key_match;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

[design/chtbl_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module chtbl_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/chtbl_hash.sv]
// Bucket hashing unit: key, 3*key+1 or decimal digit sum by reciprocal
// multiplication; remainder by bucket count, four dividend bits per cycle.
// Depends on chtbl_pkg; driven by commands from the controller.
`default_nettype none

module chtbl_hash import chtbl_pkg::*; #(
   parameter int unsigned BUCKETS = BUCKETS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire hash_cmd_type               cmd,
   input  wire logic [MODE_W-1:0]          mode,
   input  wire logic [KEY_W-1:0]           start_key,
   input  wire logic [KEY_W-1:0]           key,
   output hash_status_type                 status,
   output logic [$clog2(BUCKETS)-1:0]      bucket
);

   localparam int unsigned BUCKET_AW = $clog2(BUCKETS);

   logic [KEY_W-1:0]     work_ff, work_in;
   logic [PROD_W-1:0]    prod_ff;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [DIV_W-1:0]     div_ff, div_in;
   logic [BUCKET_AW-1:0] rem_ff, rem_in;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;

   logic [QUOT_W-1:0]    quot;
   logic [DIGIT_W-1:0]   quot10_lo;
   logic [DIGIT_W-1:0]   digit;
   logic [LIN_W-1:0]     linear;
   logic [DIV_W-1:0]     dividend;
   logic [BUCKET_AW-1:0] rem_step;

   assign quot      = prod_ff[PROD_W-1:QUOT_SHIFT];
   assign quot10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
   assign digit     = work_ff[DIGIT_W-1:0] - quot10_lo;
   assign linear    = (LIN_W'(key) << 1) + LIN_W'(key) + LIN_W'(1);

   always_comb begin
      unique case (mode)
         MODE_KEY:    dividend = DIV_W'(key);
         MODE_LINEAR: dividend = DIV_W'(linear);
         MODE_DIGITS: dividend = DIV_W'(sum_ff);
         default:     dividend = DIV_W'(key);
      endcase
   end

   always_comb begin
      logic [BUCKET_AW-1:0] r;
      logic [BUCKET_AW:0]   t;
      r = rem_ff;
      for (int i = 0; i < MOD_BITS; i++) begin
         t = {r, div_ff[DIV_W-1-i]};
         if (t >= (BUCKET_AW+1)'(BUCKETS)) begin
            t = t - (BUCKET_AW+1)'(BUCKETS);
         end
         r = t[BUCKET_AW-1:0];
      end
      rem_step = r;
   end

   always_comb begin
      work_in = work_ff;
      sum_in  = sum_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (cmd.start) begin
         work_in = start_key;
         sum_in  = '0;
      end
      if (cmd.acc) begin
         work_in = KEY_W'(quot);
         sum_in  = sum_ff + SUM_W'(digit);
      end
      if (cmd.mod_load) begin
         div_in = dividend;
         rem_in = '0;
         cnt_in = '0;
      end
      if (cmd.mod_step) begin
         div_in = {div_ff[DIV_W-MOD_BITS-1:0], {MOD_BITS{1'b0}}};
         rem_in = rem_step;
         cnt_in = cnt_ff + MOD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      work_ff <= work_in;
      sum_ff  <= sum_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      if (cmd.mul) begin
         prod_ff <= PROD_W'(work_ff) * PROD_W'(RECIP_10);
      end
   end

   assign status.work_zero = (work_ff == '0);
   assign status.mod_done  = (cnt_ff == MOD_CNT_W'(MOD_STEPS));
   assign bucket           = rem_ff;

endmodule

`default_nettype wire

[design/chtbl_dp.sv]
// Datapath of the hash table: request and result registers, the hash unit,
// the bucket head memory, the node memory and the node pool counter.
// Depends on chtbl_pkg, chtbl_hash and chtbl_ram.
`default_nettype none

module chtbl_dp import chtbl_pkg::*; #(
   parameter int unsigned BUCKETS    = BUCKETS_DEF,
   parameter int unsigned POOL_NODES = POOL_NODES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dp_cmd_type          cmd,
   output dp_status_type            status,
   input  wire logic                req_func,
   input  wire logic [KEY_W-1:0]    req_key_id,
   input  wire logic [VALUE_W-1:0]  req_entry_value,
   input  wire logic                csr_wr_en,
   input  wire logic [MODE_W-1:0]   csr_wr_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [VALUE_W-1:0]       rsp_found_value
);

   localparam int unsigned BUCKET_AW = $clog2(BUCKETS);
   localparam int unsigned NODE_AW   = $clog2(POOL_NODES);
   localparam int unsigned LINK_W    = $clog2(POOL_NODES + 1);
   localparam int unsigned NODE_W    = KEY_W + VALUE_W + LINK_W;
   localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(POOL_NODES);

   logic                 func_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic [MODE_W-1:0]    mode_ff;
   logic [LINK_W-1:0]    used_ff, used_in;
   logic [LINK_W-1:0]    ptr_ff;
   logic [BUCKET_AW-1:0] clr_idx_ff;
   status_type           res_status_ff;
   logic [VALUE_W-1:0]   res_value_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;

   hash_status_type      hash_status;
   logic [BUCKET_AW-1:0] bucket;

   logic                 head_wr_en;
   logic [BUCKET_AW-1:0] head_wr_addr;
   logic [LINK_W-1:0]    head_wr_data;
   logic [LINK_W-1:0]    head_rd_data;
   logic [NODE_W-1:0]    node_wr_data;
   logic [NODE_W-1:0]    node_rd_data;
   logic [KEY_W-1:0]     node_key;
   logic [VALUE_W-1:0]   node_value;
   logic [LINK_W-1:0]    node_link;

   chtbl_hash #(
      .BUCKETS (BUCKETS)
   ) u_hash (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd.hash),
      .mode      (mode_ff),
      .start_key (req_key_id),
      .key       (key_ff),
      .status    (hash_status),
      .bucket    (bucket)
   );

   assign head_wr_en   = cmd.clear_wr | cmd.ins_wr;
   assign head_wr_addr = cmd.clear_wr ? clr_idx_ff : bucket;
   assign head_wr_data = cmd.clear_wr ? EMPTY_LINK : used_ff;

   chtbl_ram #(
      .WIDTH (LINK_W),
      .DEPTH (BUCKETS)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (head_wr_en),
      .wr_addr (head_wr_addr),
      .wr_data (head_wr_data),
      .rd_addr (bucket),
      .rd_data (head_rd_data)
   );

   assign node_wr_data = {key_ff, value_ff, head_rd_data};

   chtbl_ram #(
      .WIDTH (NODE_W),
      .DEPTH (POOL_NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (cmd.ins_wr),
      .wr_addr (used_ff[NODE_AW-1:0]),
      .wr_data (node_wr_data),
      .rd_addr (ptr_ff[NODE_AW-1:0]),
      .rd_data (node_rd_data)
   );

   assign node_key   = node_rd_data[LINK_W+VALUE_W +: KEY_W];
   assign node_value = node_rd_data[LINK_W +: VALUE_W];
   assign node_link  = node_rd_data[LINK_W-1:0];

   assign used_in = cmd.ins_wr ? used_ff + LINK_W'(1) : used_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RESET;
         used_ff      <= '0;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         used_ff <= used_in;
         if (cmd.clear_wr) begin
            clr_idx_ff <= clr_idx_ff + BUCKET_AW'(1);
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         key_ff   <= req_key_id;
         value_ff <= req_entry_value;
      end
      if (cmd.ptr_head) begin
         ptr_ff <= head_rd_data;
      end else if (cmd.ptr_link) begin
         ptr_ff <= node_link;
      end
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         res_value_ff  <= cmd.res_value ? node_value : '0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
      end
   end

   assign status.clear_last  = (clr_idx_ff == BUCKET_AW'(BUCKETS - 1));
   assign status.mode_digits = (mode_ff == MODE_DIGITS);
   assign status.work_zero   = hash_status.work_zero;
   assign status.mod_done    = hash_status.mod_done;
   assign status.is_lookup   = (func_ff == FUNC_LOOKUP);
   assign status.pool_full   = (used_ff == LINK_W'(POOL_NODES));
   assign status.ptr_empty   = (ptr_ff == EMPTY_LINK);
   assign status.key_match   = (node_key == key_ff);
   assign status.rsp_free    = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_value_ff;

endmodule

`default_nettype wire

[design/chtbl_ctrl.sv]
// Controller state machine of the hash table: clearing pass, hashing,
// insertion, chain walk and result transfer.
// Depends on chtbl_pkg; drives the datapath by commands only.
`default_nettype none

module chtbl_ctrl import chtbl_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DIGIT_MUL;
         end
         ST_DIGIT_MUL: begin
            if (status.mode_digits && !status.work_zero) begin
               state_in = ST_DIGIT_ACC;
            end else begin
               state_in = ST_MOD;
            end
         end
         ST_DIGIT_ACC: state_in = ST_DIGIT_MUL;
         ST_MOD: begin
            if (status.mod_done) state_in = ST_HEAD;
         end
         ST_HEAD: begin
            state_in = status.is_lookup ? ST_WALK : ST_REPLY;
         end
         ST_WALK: begin
            state_in = status.ptr_empty ? ST_REPLY : ST_NODE;
         end
         ST_NODE: begin
            state_in = status.key_match ? ST_REPLY : ST_WALK;
         end
         ST_REPLY: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_wr = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load       = 1'b1;
               cmd.hash.start = 1'b1;
            end
         end
         ST_DIGIT_MUL: begin
            if (status.mode_digits && !status.work_zero) begin
               cmd.hash.mul = 1'b1;
            end else begin
               cmd.hash.mod_load = 1'b1;
            end
         end
         ST_DIGIT_ACC: cmd.hash.acc = 1'b1;
         ST_MOD: begin
            if (!status.mod_done) cmd.hash.mod_step = 1'b1;
         end
         ST_HEAD: begin
            priority if (status.is_lookup) begin
               cmd.ptr_head = 1'b1;
            end else if (status.pool_full) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = STATUS_FULL;
            end else begin
               cmd.ins_wr     = 1'b1;
               cmd.res_set    = 1'b1;
               cmd.res_status = STATUS_OK;
            end
         end
         ST_WALK: begin
            if (status.ptr_empty) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = STATUS_NOT_FOUND;
            end
         end
         ST_NODE: begin
            if (status.key_match) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = STATUS_OK;
               cmd.res_value  = 1'b1;
            end else begin
               cmd.ptr_link = 1'b1;
            end
         end
         ST_REPLY: begin
            if (status.rsp_free) cmd.rsp_load = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

[design/chained_hash_table_core.sv]
// Top level of the chained hash table: controller and datapath.
// Depends on chtbl_pkg, chtbl_ctrl and chtbl_dp.
//
// Key-value table with separate chaining. Each request inserts a key and
// value at the head of its bucket chain or looks a key up, and gives one
// response. After reset the bucket head memory is swept to empty, one
// bucket per cycle, with req_ready low until the sweep is done; csr writes
// are taken throughout. Requests are handled one at a time. The key is
// first hashed: in hash mode 2 its decimal digits are summed, by one
// reciprocal multiply and one accumulate per digit. Then the nine-step
// remainder by the bucket count gives the bucket. An insert writes the
// new node at the chain head; a lookup walks the chain, each node being
// read from the registered node memory. A finished response waits in the
// output register while the next request is accepted.
`default_nettype none

module chained_hash_table_core import chtbl_pkg::*; #(
   parameter int unsigned BUCKETS    = BUCKETS_DEF,
   parameter int unsigned POOL_NODES = POOL_NODES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_func,
   input  wire logic [KEY_W-1:0]    req_key_id,
   input  wire logic [VALUE_W-1:0]  req_entry_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [VALUE_W-1:0]       rsp_found_value,
   input  wire logic                csr_wr_en,
   input  wire logic [MODE_W-1:0]   csr_wr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   chtbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   chtbl_dp #(
      .BUCKETS    (BUCKETS),
      .POOL_NODES (POOL_NODES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_func),
      .req_key_id      (req_key_id),
      .req_entry_value (req_entry_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value)
   );

endmodule

`default_nettype wire

[design/chtbl_checker.sv]
// Port-level checks for the chained hash table core, and the bind that
// attaches them to the top level. Depends on chtbl_pkg.
`default_nettype none

module chtbl_checker import chtbl_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [VALUE_W-1:0]  rsp_found_value
);

   // A response that is not taken holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_found_value))
      else $error("response changed before its transfer");

   // Only a successful lookup carries a value; a failing status gives zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_found_value == '0)
      else $error("non-zero value with a failing status");

   // The bucket sweep after reset keeps requests out.
   assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready during the clearing pass");

   // Requests are handled one at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in progress");

endmodule

bind chained_hash_table_core chtbl_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_found_value (rsp_found_value)
);

`default_nettype wire

[test/tb_chained_hash_table_core.sv]
// Self-checking testbench for chained_hash_table_core: inserts and lookups under every hash
// mode, with a table model that predicts each response and a checker that compares them.
// Depends on chtbl_pkg and the design files of chained_hash_table_core.
module tb_chained_hash_table_core;
   import chtbl_pkg::*;

   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam logic [KEY_W-1:0] KEY_MAX = '1;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int unsigned LIMIT_CYCLES = 4000000;

   typedef struct packed {
      status_type status;
      logic [VALUE_W-1:0] value;
   } reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_func = FUNC_INSERT;
   logic [KEY_W-1:0] req_key_id = '0;
   logic [VALUE_W-1:0] req_entry_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [VALUE_W-1:0] rsp_found_value;
   logic csr_wr_en = 1'b0;
   logic [MODE_W-1:0] csr_wr_data = MODE_RESET;

   logic [MODE_W-1:0] mode_setting = MODE_RESET;
   int chain_head [BUCKETS_DEF];
   logic [KEY_W-1:0] node_key [POOL_NODES_DEF];
   logic [VALUE_W-1:0] node_value [POOL_NODES_DEF];
   int node_link [POOL_NODES_DEF];
   int pool_used = 0;

   reply_type replies_due [$];
   logic [KEY_W-1:0] known_keys [$];
   int burst_left = 0;
   int failures = 0;
   int unsigned cycle_count = 0;
   int unsigned ready_tick = 0;
   int hold_left = 0;
   bit hold_off_request = 1'b0;

   chained_hash_table_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_key_id(req_key_id),
      .req_entry_value(req_entry_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_found_value(rsp_found_value),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("chained_hash_table_core test failed");
         $finish;
      end
   end

   function automatic int chain_of(logic [KEY_W-1:0] key);
      longint unsigned h;
      longint unsigned sum;
      h = 64'(key);
      if (mode_setting == MODE_LINEAR) begin
         h = h * 3 + 1;
      end else if (mode_setting == MODE_DIGITS) begin
         sum = 0;
         while (h != 0) begin
            sum += h % 10;
            h /= 10;
         end
         h = sum;
      end
      return int'(h % BUCKETS_DEF);
   endfunction

   function automatic reply_type apply_request(logic func, logic [KEY_W-1:0] key,
                                               logic [VALUE_W-1:0] value);
      reply_type r;
      int b;
      int p;
      int steps;
      b = chain_of(key);
      r.status = STATUS_OK;
      r.value = '0;
      if (func == FUNC_INSERT) begin
         if (pool_used >= POOL_NODES_DEF) begin
            r.status = STATUS_FULL;
         end else begin
            node_key[pool_used] = key;
            node_value[pool_used] = value;
            node_link[pool_used] = chain_head[b];
            chain_head[b] = pool_used;
            pool_used++;
         end
      end else begin
         r.status = STATUS_NOT_FOUND;
         p = chain_head[b];
         steps = 0;
         while (p < POOL_NODES_DEF && steps < POOL_NODES_DEF) begin
            if (node_key[p] == key) begin
               r.status = STATUS_OK;
               r.value = node_value[p];
               break;
            end
            p = node_link[p];
            steps++;
         end
      end
      return r;
   endfunction

   function automatic logic [KEY_W-1:0] fresh_key();
      int pick;
      logic [31:0] word;
      pick = $urandom_range(0, 19);
      word = $urandom();
      if (pick == 0) return KEY_MAX;
      if (pick == 1) return '0;
      if (pick < 6) return KEY_W'($urandom_range(0, 999));
      if (pick < 9) return KEY_W'($urandom_range(0, 32'(KEY_MAX / 20)) * 20);
      if (pick < 12 && known_keys.size() != 0)
         return known_keys[$urandom_range(0, known_keys.size() - 1)];
      return word[KEY_W-1:0];
   endfunction

   function automatic logic [VALUE_W-1:0] fresh_value();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return $urandom();
   endfunction

   task automatic send_item(input logic func, input logic [KEY_W-1:0] key,
                            input logic [VALUE_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 10);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_key_id <= key;
      req_entry_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      replies_due.push_back(apply_request(func, key, value));
      if (func == FUNC_INSERT) begin
         known_keys.push_back(key);
         if (known_keys.size() > 400) void'(known_keys.pop_front());
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_hash_mode(input logic [MODE_W-1:0] mode);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mode_setting = mode;
   endtask

   task automatic run_traffic(input int count, input int insert_pct);
      logic func;
      logic [KEY_W-1:0] key;
      for (int n = 0; n < count; n++) begin
         func = ($urandom_range(1, 100) <= insert_pct) ? FUNC_INSERT : FUNC_LOOKUP;
         if (func == FUNC_LOOKUP && known_keys.size() != 0 && $urandom_range(0, 3) != 0)
            key = known_keys[$urandom_range(0, known_keys.size() - 1)];
         else
            key = fresh_key();
         send_item(func, key, fresh_value());
      end
   endtask

   task automatic test_reset_mode_table();
      send_item(FUNC_INSERT, '0, '0);
      send_item(FUNC_INSERT, KEY_MAX, '1);
      send_item(FUNC_INSERT, 19, 32'hA5A5_A5A5);
      send_item(FUNC_INSERT, 91, 32'h5A5A_5A5A);
      send_item(FUNC_INSERT, 12345, 32'h0000_0001);
      send_item(FUNC_INSERT, 12345, 32'h8000_0002);
      send_item(FUNC_LOOKUP, '0, '1);
      send_item(FUNC_LOOKUP, KEY_MAX, '0);
      send_item(FUNC_LOOKUP, 19, fresh_value());
      send_item(FUNC_LOOKUP, 91, fresh_value());
      send_item(FUNC_LOOKUP, 12345, fresh_value());
      send_item(FUNC_LOOKUP, 28, fresh_value());
      send_item(FUNC_LOOKUP, 7, fresh_value());
   endtask

   task automatic test_hash_modes();
      set_hash_mode(MODE_KEY);
      send_item(FUNC_INSERT, 40, 32'h1234_5678);
      send_item(FUNC_LOOKUP, 40, '0);
      set_hash_mode(MODE_LINEAR);
      send_item(FUNC_INSERT, KEY_MAX, 32'hFEDC_BA98);
      send_item(FUNC_LOOKUP, KEY_MAX, '0);
      set_hash_mode(MODE_SPARE);
      send_item(FUNC_INSERT, KEY_MAX - 20, 32'h0F0F_0F0F);
      send_item(FUNC_LOOKUP, KEY_MAX - 20, '0);
   endtask

   task automatic test_random_traffic();
      set_hash_mode(MODE_KEY);
      run_traffic(190, 30);
      set_hash_mode(MODE_LINEAR);
      run_traffic(190, 30);
      set_hash_mode(MODE_SPARE);
      hold_off_request = 1'b1;
      run_traffic(190, 30);
      set_hash_mode(MODE_DIGITS);
      run_traffic(190, 30);
      set_hash_mode(MODE_KEY);
      run_traffic(190, 30);
   endtask

   task automatic test_pool_exhaustion();
      while (pool_used < POOL_NODES_DEF) send_item(FUNC_INSERT, fresh_key(), fresh_value());
      repeat (4) send_item(FUNC_INSERT, fresh_key(), fresh_value());
      send_item(FUNC_INSERT, KEY_MAX, '1);
      repeat (6) send_item(FUNC_LOOKUP, known_keys[$urandom_range(0, known_keys.size() - 1)],
                           fresh_value());
   endtask

   always @(posedge clock) begin
      ready_tick++;
      if (hold_off_request) begin
         hold_left = HOLD_OFF_CYCLES;
         hold_off_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if ((ready_tick / 300) % 4 == 0) begin
         rsp_ready <= 1'b1;
      end else if ((ready_tick / 300) % 4 == 1) begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end else if ((ready_tick / 300) % 4 == 2) begin
         rsp_ready <= ($urandom_range(0, 9) < 3);
      end else begin
         rsp_ready <= ready_tick[1];
      end
   end

   always @(posedge clock) begin
      reply_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (replies_due.size() == 0) begin
            $error("response transfer with no request outstanding: status %0d", rsp_status);
            failures++;
         end else begin
            due = replies_due.pop_front();
            if (rsp_status !== due.status) begin
               $error("status: expected %0d, got %0d", due.status, rsp_status);
               failures++;
            end
            if (rsp_found_value !== due.value) begin
               $error("found_value: expected %h, got %h", due.value, rsp_found_value);
               failures++;
            end
         end
      end
   end

   initial begin
      foreach (chain_head[b]) chain_head[b] = POOL_NODES_DEF;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_mode_table();
      test_hash_modes();
      test_random_traffic();
      test_pool_exhaustion();
      settle();
      if (failures == 0 && replies_due.size() == 0) begin
         $display("chained_hash_table_core test passed");
      end else begin
         $display("chained_hash_table_core test failed");
      end
      $finish;
   end

endmodule
